### hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define LMSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LMSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lmss_pkg.sv
`default_nettype none

package lmss_pkg;

  localparam int ID_W  = 10;
  localparam int SID_W = 8;
  localparam int CMD_W = 4;
  localparam int ST_W  = 3;

  localparam int DEF_NUM_STACKS   = 256;
  localparam int DEF_NUM_ELEMENTS = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH        = 4'd0,
    CMD_POP         = 4'd1,
    CMD_TRY_POP     = 4'd2,
    CMD_REMOVE      = 4'd3,
    CMD_IN_STACK    = 4'd4,
    CMD_EXCHANGE    = 4'd5,
    CMD_TOP         = 4'd6,
    CMD_NEXT        = 4'd7,
    CMD_REMOVE_NEXT = 4'd8,
    CMD_IS_EMPTY    = 4'd9
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RESERVED = 3'd1,
    ST_LINKED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_POP,
    S_WALK,
    S_RM_CLR,
    S_RN_LINK,
    S_RN_CLR,
    S_EX_NY,
    S_EX_W1,
    S_EX_W2,
    S_EX_W3,
    S_EX_W4,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SID_W-1:0] stack_id;
    logic [ID_W-1:0]  element;
    logic [ID_W-1:0]  other_element;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_element;
    logic            flag;
    logic [ST_W-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

### hdl/lmss_ram.sv
`default_nettype none

module lmss_ram #(
  parameter  int DEPTH = 2,
  parameter  int WIDTH = 1,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/lmss_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module lmss_ctrl #(
  parameter  int NUM_STACKS   = lmss_pkg::DEF_NUM_STACKS,
  parameter  int NUM_ELEMENTS = lmss_pkg::DEF_NUM_ELEMENTS,
  localparam int SW           = $clog2(NUM_STACKS),
  localparam int EW           = $clog2(NUM_ELEMENTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire lmss_pkg::req_t               req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output lmss_pkg::rsp_t                    rsp,
  output logic                              top_we,
  output logic [SW-1:0]                     top_waddr,
  output logic [lmss_pkg::ID_W-1:0]         top_wdata,
  output logic [SW-1:0]                     top_raddr,
  input  wire logic [lmss_pkg::ID_W-1:0]    top_rdata,
  output logic                              next_we,
  output logic [EW-1:0]                     next_waddr,
  output logic [lmss_pkg::ID_W-1:0]         next_wdata,
  output logic [EW-1:0]                     next_raddr,
  input  wire logic [lmss_pkg::ID_W-1:0]    next_rdata
);

  localparam int CLR_N = (NUM_STACKS > NUM_ELEMENTS) ? NUM_STACKS : NUM_ELEMENTS;
  localparam int CW    = $clog2(CLR_N);
  localparam int SCW   = $clog2(NUM_ELEMENTS + 1);
  localparam logic [SCW-1:0] WALK_MAX = SCW'(NUM_ELEMENTS);
  localparam logic [CW-1:0]  CLR_LAST = CW'(CLR_N - 1);

  function automatic logic [SW-1:0] sidx(input logic [31:0] w);
    return w[SW-1:0];
  endfunction

  function automatic logic [EW-1:0] eidx(input logic [31:0] w);
    return w[EW-1:0];
  endfunction

  lmss_pkg::state_t  state, state_next;
  lmss_pkg::cmd_t    cmd;
  lmss_pkg::status_t st;

  logic [lmss_pkg::SID_W-1:0] sid;
  logic [lmss_pkg::ID_W-1:0]  x, y, tos, nx, prev, pred_x, pred_y, a_fin, b_fin, res;
  logic                       flag, s_ok, x_ok, y_ok, first, phase;
  logic [SCW-1:0]             steps;
  logic [CW-1:0]              clr_cnt;

  logic [lmss_pkg::ID_W-1:0]  cur, target, a_mid, b_mid, a_pre, b_pre;
  logic                       walk_end, walk_hit, arg_err;

  always_comb begin
    cur      = first ? tos : next_rdata;
    target   = phase ? y : x;
    walk_end = (cur == '0) || (steps == WALK_MAX);
    walk_hit = !walk_end && (cur == target);
    a_mid    = (pred_y == x) ? x : nx;
    a_pre    = (a_mid == y) ? x : a_mid;
    b_mid    = (pred_x == y) ? y : next_rdata;
    b_pre    = (b_mid == x) ? y : b_mid;
  end

  always_comb begin
    case (cmd) inside
      lmss_pkg::CMD_PUSH, lmss_pkg::CMD_TRY_POP,
      lmss_pkg::CMD_REMOVE, lmss_pkg::CMD_IN_STACK:  arg_err = !s_ok || !x_ok;
      lmss_pkg::CMD_POP, lmss_pkg::CMD_TOP,
      lmss_pkg::CMD_IS_EMPTY:                        arg_err = !s_ok;
      lmss_pkg::CMD_NEXT, lmss_pkg::CMD_REMOVE_NEXT: arg_err = !x_ok;
      lmss_pkg::CMD_EXCHANGE:                        arg_err = !s_ok || !x_ok || !y_ok;
      default:                                       arg_err = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lmss_pkg::S_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = lmss_pkg::S_IDLE;
      end
      lmss_pkg::S_IDLE: begin
        if (req_valid) state_next = lmss_pkg::S_READ;
      end
      lmss_pkg::S_READ: begin
        state_next = lmss_pkg::S_DONE;
        if (!arg_err) begin
          case (cmd)
            lmss_pkg::CMD_POP: begin
              if (top_rdata != '0) state_next = lmss_pkg::S_POP;
            end
            lmss_pkg::CMD_REMOVE, lmss_pkg::CMD_IN_STACK: state_next = lmss_pkg::S_WALK;
            lmss_pkg::CMD_EXCHANGE: begin
              if (x != y) state_next = lmss_pkg::S_WALK;
            end
            lmss_pkg::CMD_REMOVE_NEXT: begin
              if (next_rdata != '0) state_next = lmss_pkg::S_RN_LINK;
            end
            default: state_next = lmss_pkg::S_DONE;
          endcase
        end
      end
      lmss_pkg::S_POP:     state_next = lmss_pkg::S_DONE;
      lmss_pkg::S_WALK: begin
        if (walk_end) begin
          state_next = lmss_pkg::S_DONE;
        end else if (walk_hit) begin
          case (cmd)
            lmss_pkg::CMD_REMOVE: begin
              state_next = (prev == '0) ? lmss_pkg::S_DONE : lmss_pkg::S_RM_CLR;
            end
            lmss_pkg::CMD_EXCHANGE: begin
              state_next = phase ? lmss_pkg::S_EX_NY : lmss_pkg::S_WALK;
            end
            default: state_next = lmss_pkg::S_DONE;
          endcase
        end
      end
      lmss_pkg::S_RM_CLR:  state_next = lmss_pkg::S_DONE;
      lmss_pkg::S_RN_LINK: state_next = lmss_pkg::S_RN_CLR;
      lmss_pkg::S_RN_CLR:  state_next = lmss_pkg::S_DONE;
      lmss_pkg::S_EX_NY:   state_next = lmss_pkg::S_EX_W1;
      lmss_pkg::S_EX_W1:   state_next = lmss_pkg::S_EX_W2;
      lmss_pkg::S_EX_W2:   state_next = lmss_pkg::S_EX_W3;
      lmss_pkg::S_EX_W3:   state_next = lmss_pkg::S_EX_W4;
      lmss_pkg::S_EX_W4:   state_next = lmss_pkg::S_DONE;
      lmss_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = lmss_pkg::S_IDLE;
      end
      default: state_next = lmss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != lmss_pkg::S_IDLE);
    top_raddr  = sidx(32'(sid));
    next_raddr = eidx(32'(x));
    top_we     = 1'b0;
    top_waddr  = sidx(32'(sid));
    top_wdata  = '0;
    next_we    = 1'b0;
    next_waddr = eidx(32'(x));
    next_wdata = '0;
    unique case (state)
      lmss_pkg::S_CLEAR: begin
        top_we     = 32'(clr_cnt) < NUM_STACKS;
        top_waddr  = sidx(32'(clr_cnt));
        next_we    = 32'(clr_cnt) < NUM_ELEMENTS;
        next_waddr = eidx(32'(clr_cnt));
      end
      lmss_pkg::S_IDLE: begin
        top_raddr  = sidx(32'(req.stack_id));
        next_raddr = eidx(32'(req.element));
      end
      lmss_pkg::S_READ: begin
        next_raddr = (cmd == lmss_pkg::CMD_POP) ? eidx(32'(top_rdata)) : eidx(32'(next_rdata));
        if (!arg_err) begin
          case (cmd)
            lmss_pkg::CMD_PUSH: begin
              if (next_rdata == '0 && top_rdata != x) begin
                top_we     = 1'b1;
                top_wdata  = x;
                next_we    = 1'b1;
                next_wdata = top_rdata;
              end
            end
            lmss_pkg::CMD_TRY_POP: begin
              if (top_rdata == x) begin
                top_we    = 1'b1;
                top_wdata = next_rdata;
                next_we   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      lmss_pkg::S_POP: begin
        top_we     = 1'b1;
        top_wdata  = next_rdata;
        next_we    = 1'b1;
        next_waddr = eidx(32'(tos));
      end
      lmss_pkg::S_WALK: begin
        next_raddr = eidx(32'(cur));
        if (walk_hit && cmd == lmss_pkg::CMD_REMOVE) begin
          if (prev == '0) begin
            top_we    = 1'b1;
            top_wdata = nx;
            next_we   = 1'b1;
          end else begin
            next_we    = 1'b1;
            next_waddr = eidx(32'(prev));
            next_wdata = nx;
          end
        end
      end
      lmss_pkg::S_RM_CLR: next_we = 1'b1;
      lmss_pkg::S_RN_LINK: begin
        next_we    = 1'b1;
        next_wdata = next_rdata;
      end
      lmss_pkg::S_RN_CLR: begin
        next_we    = 1'b1;
        next_waddr = eidx(32'(res));
      end
      lmss_pkg::S_EX_W1: begin
        if (pred_x == '0) begin
          top_we    = 1'b1;
          top_wdata = y;
        end else begin
          next_we    = 1'b1;
          next_waddr = eidx(32'(pred_x));
          next_wdata = y;
        end
      end
      lmss_pkg::S_EX_W2: begin
        if (pred_y == '0) begin
          top_we    = 1'b1;
          top_wdata = x;
        end else begin
          next_we    = 1'b1;
          next_waddr = eidx(32'(pred_y));
          next_wdata = x;
        end
      end
      lmss_pkg::S_EX_W3: begin
        next_we    = 1'b1;
        next_wdata = b_fin;
      end
      lmss_pkg::S_EX_W4: begin
        next_we    = 1'b1;
        next_waddr = eidx(32'(y));
        next_wdata = a_fin;
      end
      lmss_pkg::S_EX_NY, lmss_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lmss_pkg::S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lmss_pkg::S_CLEAR) clr_cnt <= clr_cnt + CW'(1);
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (state == lmss_pkg::S_DONE && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lmss_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.result_element <= res;
      rsp.flag           <= flag;
      rsp.status         <= st;
    end
    case (state)
      lmss_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd  <= lmss_pkg::cmd_t'(req.command);
          sid  <= req.stack_id;
          x    <= req.element;
          y    <= req.other_element;
          s_ok <= (req.stack_id != '0) && (32'(req.stack_id) < NUM_STACKS);
          x_ok <= (req.element != '0) && (32'(req.element) < NUM_ELEMENTS);
          y_ok <= (req.other_element != '0) && (32'(req.other_element) < NUM_ELEMENTS);
          res  <= '0;
          flag <= 1'b0;
          st   <= lmss_pkg::ST_OK;
        end
      end
      lmss_pkg::S_READ: begin
        tos   <= top_rdata;
        nx    <= next_rdata;
        first <= 1'b1;
        phase <= 1'b0;
        prev  <= '0;
        steps <= '0;
        if (arg_err) begin
          st <= lmss_pkg::ST_RESERVED;
        end else begin
          case (cmd)
            lmss_pkg::CMD_PUSH: begin
              if (next_rdata != '0 || top_rdata == x) st <= lmss_pkg::ST_LINKED;
              else flag <= 1'b1;
            end
            lmss_pkg::CMD_POP: begin
              if (top_rdata == '0) begin
                st <= lmss_pkg::ST_EMPTY;
              end else begin
                res  <= top_rdata;
                flag <= 1'b1;
              end
            end
            lmss_pkg::CMD_TRY_POP: begin
              if (top_rdata == x) begin
                res  <= x;
                flag <= 1'b1;
              end
            end
            lmss_pkg::CMD_EXCHANGE: begin
              if (x == y) st <= lmss_pkg::ST_MISSING;
            end
            lmss_pkg::CMD_TOP: begin
              res  <= top_rdata;
              flag <= (top_rdata != '0);
            end
            lmss_pkg::CMD_NEXT: begin
              res  <= next_rdata;
              flag <= (next_rdata != '0);
            end
            lmss_pkg::CMD_REMOVE_NEXT: begin
              if (next_rdata != '0) begin
                res  <= next_rdata;
                flag <= 1'b1;
              end
            end
            lmss_pkg::CMD_IS_EMPTY: flag <= (top_rdata == '0);
            default: ;
          endcase
        end
      end
      lmss_pkg::S_WALK: begin
        if (walk_end) begin
          if (cmd == lmss_pkg::CMD_EXCHANGE) st <= lmss_pkg::ST_MISSING;
        end else if (walk_hit) begin
          case (cmd)
            lmss_pkg::CMD_IN_STACK: flag <= 1'b1;
            lmss_pkg::CMD_REMOVE: begin
              res  <= x;
              flag <= 1'b1;
            end
            lmss_pkg::CMD_EXCHANGE: begin
              if (!phase) begin
                pred_x <= prev;
                phase  <= 1'b1;
                first  <= 1'b1;
                prev   <= '0;
                steps  <= '0;
              end else begin
                pred_y <= prev;
              end
            end
            default: ;
          endcase
        end else begin
          prev  <= cur;
          steps <= steps + SCW'(1);
          first <= 1'b0;
        end
      end
      lmss_pkg::S_EX_NY: begin
        a_fin <= a_pre;
        b_fin <= b_pre;
        flag  <= 1'b1;
      end
      default: ;
    endcase
  end

  `LMSS_ASSERT_IMP(a_idle_no_write, clk, rst, state == lmss_pkg::S_IDLE, !top_we && !next_we, "memory written while idle")
  `LMSS_ASSERT_IMP(a_walk_bound, clk, rst, state == lmss_pkg::S_WALK, steps <= WALK_MAX, "list walk past its bound")
  `LMSS_ASSERT_IMP(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(state) == lmss_pkg::S_DONE, "response loaded outside done")
  `LMSS_ASSERT_NXT(a_clear_len, clk, rst, state == lmss_pkg::S_CLEAR && clr_cnt != CLR_LAST, state == lmss_pkg::S_CLEAR, "clearing pass cut short")

endmodule

`default_nettype wire

### hdl/linked_multi_stack_store.sv
// Many LIFO stacks over one shared link store.
// req channel: one command word (command, stack_id, element, other_element)
// is taken when req_valid is high and req_stall is low. rsp channel: one
// result word (result_element, flag, status) per command, taken when
// rsp_valid is high and rsp_stall is low.
// One command is in work at a time. States it passes before S_DONE:
//   push, try_pop, top, next, is_empty, bad ids, empty pop: read
//   pop: read, pop; remove_next: read, relink, clear (no successor: read)
//   remove, in_stack: read, walk; remove adds a clear if x is not the top
//   exchange: read, walk for x, walk for y, S_EX_NY, S_EX_W1 to S_EX_W4
// The next command can be taken in the cycle after the result enters the
// output register. The walks visit one link per cycle, bounded by the single
// read port of the link memory.
// After reset both memories are cleared, one entry a cycle, at each address
// below max(NUM_STACKS, NUM_ELEMENTS) (1024 by default); req_stall is high
// meanwhile. A held result waits in the output register while rsp_stall is
// high; a new command is still taken then, and its result waits until the
// register drains.
`default_nettype none

module linked_multi_stack_store #(
  parameter int NUM_STACKS   = lmss_pkg::DEF_NUM_STACKS,
  parameter int NUM_ELEMENTS = lmss_pkg::DEF_NUM_ELEMENTS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire lmss_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output lmss_pkg::rsp_t      rsp
);

  localparam int SW = $clog2(NUM_STACKS);
  localparam int EW = $clog2(NUM_ELEMENTS);

  logic                      top_we, next_we;
  logic [SW-1:0]             top_waddr, top_raddr;
  logic [EW-1:0]             next_waddr, next_raddr;
  logic [lmss_pkg::ID_W-1:0] top_wdata, top_rdata, next_wdata, next_rdata;

  lmss_ctrl #(
    .NUM_STACKS   (NUM_STACKS),
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .top_we     (top_we),
    .top_waddr  (top_waddr),
    .top_wdata  (top_wdata),
    .top_raddr  (top_raddr),
    .top_rdata  (top_rdata),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .next_raddr (next_raddr),
    .next_rdata (next_rdata)
  );

  lmss_ram #(
    .DEPTH (NUM_STACKS),
    .WIDTH (lmss_pkg::ID_W)
  ) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .raddr (top_raddr),
    .rdata (top_rdata)
  );

  lmss_ram #(
    .DEPTH (NUM_ELEMENTS),
    .WIDTH (lmss_pkg::ID_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

endmodule

`default_nettype wire

### bench/linked_multi_stack_store_tb.sv
module linked_multi_stack_store_tb;
  import lmss_pkg::*;

  localparam int N_STACKS = DEF_NUM_STACKS;
  localparam int N_ELEMS = DEF_NUM_ELEMENTS;
  localparam int RANDOM_WORDS = 400;
  localparam logic [CMD_W-1:0] CMD_SPARE = 4'hF;

  typedef struct {
    req_t word;
    bit   settle;
  } queued_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [ID_W-1:0] stack_top [N_STACKS];
  logic [ID_W-1:0] link_of [N_ELEMS];
  int busy_stacks [4] = '{1, 2, 3, 255};

  queued_t words_to_send [$];
  rsp_t replies_due [$];
  queued_t head;
  rsp_t want;
  int words_taken = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  wire holding = hold_left != 0;
  wire quiet = words_taken >= 250 && words_taken < 330;

  linked_multi_stack_store #(
    .NUM_STACKS(N_STACKS),
    .NUM_ELEMENTS(N_ELEMS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (stack_top[i]) stack_top[i] = '0;
    foreach (link_of[i]) link_of[i] = '0;
  end

  function automatic bit find_in_stack(int s, int e, output int pred);
    int prev;
    int cur;
    prev = 0;
    cur = int'(stack_top[s]);
    pred = 0;
    for (int n = 0; n < N_ELEMS && cur != 0; n++) begin
      if (cur == e) begin
        pred = prev;
        return 1'b1;
      end
      prev = cur;
      cur = int'(link_of[cur]);
    end
    return 1'b0;
  endfunction

  function automatic void relink(int s, int pred, int v);
    if (pred == 0) stack_top[s] = ID_W'(v);
    else link_of[pred] = ID_W'(v);
  endfunction

  function automatic rsp_t store_reply(req_t w);
    rsp_t r;
    int s, x, y, px, py, t;
    bit sid_ok, x_ok, y_ok;
    r = '0;
    s = int'(w.stack_id);
    x = int'(w.element);
    y = int'(w.other_element);
    sid_ok = s != 0 && s < N_STACKS;
    x_ok = x != 0 && x < N_ELEMS;
    y_ok = y != 0 && y < N_ELEMS;
    case (w.command)
      CMD_PUSH: begin
        if (!sid_ok || !x_ok) r.status = ST_RESERVED;
        else if (link_of[x] != 0 || int'(stack_top[s]) == x) r.status = ST_LINKED;
        else begin
          link_of[x] = stack_top[s];
          stack_top[s] = ID_W'(x);
          r.flag = 1'b1;
        end
      end
      CMD_POP: begin
        if (!sid_ok) r.status = ST_RESERVED;
        else if (stack_top[s] == 0) r.status = ST_EMPTY;
        else begin
          t = int'(stack_top[s]);
          stack_top[s] = link_of[t];
          link_of[t] = '0;
          r.result_element = ID_W'(t);
          r.flag = 1'b1;
        end
      end
      CMD_TRY_POP: begin
        if (!sid_ok || !x_ok) r.status = ST_RESERVED;
        else if (int'(stack_top[s]) == x) begin
          stack_top[s] = link_of[x];
          link_of[x] = '0;
          r.result_element = ID_W'(x);
          r.flag = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!sid_ok || !x_ok) r.status = ST_RESERVED;
        else if (find_in_stack(s, x, px)) begin
          relink(s, px, int'(link_of[x]));
          link_of[x] = '0;
          r.result_element = ID_W'(x);
          r.flag = 1'b1;
        end
      end
      CMD_IN_STACK: begin
        if (!sid_ok || !x_ok) r.status = ST_RESERVED;
        else r.flag = find_in_stack(s, x, px);
      end
      CMD_EXCHANGE: begin
        if (!sid_ok || !x_ok || !y_ok) r.status = ST_RESERVED;
        else if (x == y || !find_in_stack(s, x, px) || !find_in_stack(s, y, py))
          r.status = ST_MISSING;
        else begin
          relink(s, px, y);
          relink(s, py, x);
          if (int'(link_of[x]) == y) link_of[x] = ID_W'(x);
          if (int'(link_of[y]) == x) link_of[y] = ID_W'(y);
          t = int'(link_of[x]);
          link_of[x] = link_of[y];
          link_of[y] = ID_W'(t);
          r.flag = 1'b1;
        end
      end
      CMD_TOP: begin
        if (!sid_ok) r.status = ST_RESERVED;
        else begin
          r.result_element = stack_top[s];
          r.flag = stack_top[s] != 0;
        end
      end
      CMD_NEXT: begin
        if (!x_ok) r.status = ST_RESERVED;
        else begin
          r.result_element = link_of[x];
          r.flag = link_of[x] != 0;
        end
      end
      CMD_REMOVE_NEXT: begin
        if (!x_ok) r.status = ST_RESERVED;
        else begin
          t = int'(link_of[x]);
          if (t != 0) begin
            link_of[x] = link_of[t];
            link_of[t] = '0;
            r.result_element = ID_W'(t);
            r.flag = 1'b1;
          end
        end
      end
      CMD_IS_EMPTY: begin
        if (!sid_ok) r.status = ST_RESERVED;
        else r.flag = stack_top[s] == 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_element(int e);
    int p;
    if (link_of[e] != 0) return 1'b0;
    foreach (busy_stacks[i])
      if (find_in_stack(busy_stacks[i], e, p)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_member(int s, int fallback);
    int cur;
    cur = int'(stack_top[s]);
    if ($urandom_range(0, 99) >= 75) return fallback;
    for (int k = $urandom_range(0, 5); k > 0 && cur != 0; k--) cur = int'(link_of[cur]);
    return (cur != 0) ? cur : fallback;
  endfunction

  function automatic req_t pick_word();
    req_t w;
    int s, x, y, p;
    s = busy_stacks[$urandom_range(0, 3)];
    p = $urandom_range(0, 99);
    if (p < 3) s = 0;
    else if (p < 8) s = $urandom_range(1, 255);
    x = $urandom_range(1, 24);
    y = $urandom_range(0, 1023);
    p = $urandom_range(0, 99);
    if (p < 30) begin
      w.command = CMD_PUSH;
      for (int k = 0; k < 8 && !idle_element(x); k++) x = $urandom_range(1, 24);
      if ($urandom_range(0, 99) < 8) x = $urandom_range(0, 24);
    end else if (p < 40) begin
      w.command = CMD_POP;
    end else if (p < 48) begin
      w.command = CMD_TRY_POP;
      if ($urandom_range(0, 99) < 70) x = int'(stack_top[s]);
    end else if (p < 58) begin
      w.command = CMD_REMOVE;
      x = pick_member(s, x);
    end else if (p < 66) begin
      w.command = CMD_IN_STACK;
      x = pick_member(s, x);
    end else if (p < 78) begin
      w.command = CMD_EXCHANGE;
      x = pick_member(s, x);
      y = pick_member(s, $urandom_range(1, 24));
      if ($urandom_range(0, 99) < 4) y = $urandom_range(0, 1023);
    end else if (p < 83) begin
      w.command = CMD_TOP;
    end else if (p < 88) begin
      w.command = CMD_NEXT;
    end else if (p < 93) begin
      w.command = CMD_REMOVE_NEXT;
    end else if (p < 97) begin
      w.command = CMD_IS_EMPTY;
    end else begin
      w.command = CMD_W'($urandom_range(CMD_IS_EMPTY + 1, CMD_SPARE));
    end
    if ($urandom_range(0, 99) < 4) x = $urandom_range(0, 1023);
    w.stack_id = SID_W'(s);
    w.element = ID_W'(x);
    w.other_element = ID_W'(y);
    return w;
  endfunction

  function automatic void queue_word(logic [CMD_W-1:0] c, int s, int x, int y = -1);
    req_t w;
    w.command = c;
    w.stack_id = SID_W'(s);
    w.element = ID_W'(x);
    w.other_element = ID_W'((y < 0) ? int'($urandom_range(0, 1023)) : y);
    words_to_send.push_back('{word: w, settle: 1'b0});
  endfunction

  task automatic note_mismatch(rsp_t exp_r, rsp_t got_r, bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected word: elem=%0d flag=%0d status=%0d",
                 got_r.result_element, got_r.flag, got_r.status);
      else
        $display("mismatch: expected elem=%0d flag=%0d status=%0d, got elem=%0d flag=%0d status=%0d",
                 exp_r.result_element, exp_r.flag, exp_r.status,
                 got_r.result_element, got_r.flag, got_r.status);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        replies_due.push_back(store_reply(req));
        words_taken <= words_taken + 1;
      end
      if (!req_valid || !req_stall) begin
        if (words_to_send.size() != 0
            && !(words_to_send[0].settle && replies_due.size() != 0)
            && (quiet || $urandom_range(0, 99) >= 38)) begin
          head = words_to_send.pop_front();
          req <= head.word;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // hold the result side off once the block has taken a hundred words
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= 100) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          note_mismatch(rsp, rsp, 1'b1);
        end else begin
          want = replies_due.pop_front();
          if (rsp.result_element !== want.result_element || rsp.flag !== want.flag
              || rsp.status !== want.status)
            note_mismatch(want, rsp, 1'b0);
        end
      end
      rsp_stall <= holding || (!quiet && $urandom_range(0, 99) < 38);
    end
  end

  initial begin
    int n;
    req_t w;
    queue_word(CMD_PUSH, 1, 0);
    queue_word(CMD_PUSH, 0, 5);
    queue_word(CMD_POP, 1, 7);
    queue_word(CMD_REMOVE, 1, 5);
    queue_word(CMD_IS_EMPTY, 1, 0);
    queue_word(CMD_PUSH, 1, 1023);
    queue_word(CMD_PUSH, 1, 1023);
    queue_word(CMD_PUSH, 1, 1);
    queue_word(CMD_PUSH, 255, 1);
    queue_word(CMD_PUSH, 255, 2);
    queue_word(CMD_TRY_POP, 1, 1023);
    queue_word(CMD_PUSH, 1, 3);
    queue_word(CMD_EXCHANGE, 1, 3, 1023);
    queue_word(CMD_EXCHANGE, 1, 1, 1);
    queue_word(CMD_EXCHANGE, 1, 1, 2);
    queue_word(CMD_EXCHANGE, 1, 1, 0);
    queue_word(CMD_REMOVE, 1, 1);
    queue_word(CMD_REMOVE_NEXT, 0, 1023);
    queue_word(CMD_REMOVE_NEXT, 0, 1023);
    queue_word(CMD_POP, 1, 0);
    // close a loop on stack 255, walk it, then cut it open again
    queue_word(CMD_PUSH, 255, 4);
    queue_word(CMD_PUSH, 255, 2);
    queue_word(CMD_IN_STACK, 255, 9);
    queue_word(CMD_REMOVE_NEXT, 0, 2);
    queue_word(CMD_REMOVE_NEXT, 0, 2);
    queue_word(CMD_TRY_POP, 255, 2);
    queue_word(CMD_NEXT, 0, 0);
    queue_word(CMD_TOP, 0, 0);
    queue_word(CMD_SPARE, 255, 1023);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    n = 0;
    while (n < RANDOM_WORDS) begin
      @(negedge clk);
      if (words_to_send.size() == 0) begin
        w = pick_word();
        words_to_send.push_back('{word: w, settle: n == 0 || n == 200});
        if (w.command <= CMD_IS_EMPTY) n++;
      end
    end
    while (words_to_send.size() != 0 || req_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

endmodule

### linked_multi_stack_store.f
+incdir+hdl
hdl/lmss_pkg.sv
hdl/lmss_ram.sv
hdl/lmss_ctrl.sv
hdl/linked_multi_stack_store.sv
bench/linked_multi_stack_store_tb.sv
